@@ sv/fdmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared constants, types and register codes of the frame difference
// motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

    localparam int MAX_WIDTH   = 640;
    localparam int MAX_HEIGHT  = 480;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int THR_W    = 9;
    localparam int THR_SQ_W = 2 * THR_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int CNT_W    = 19;
    localparam int CFG_W    = 10;
    localparam int IDX_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};

    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(90);
    localparam logic [COL_W-1:0] WIDTH_RST     = COL_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RST    = ROW_W'(480);
    localparam logic             MIRROR_RST    = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_MIRROR    = 2'd3
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // what travels down the pipeline beside the pixel data
    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        tag_t              tag;
    } pos_t;

endpackage

@@ sv/frame_difference_motion_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_motion_detect
// Frame differencing motion detector on an RGB888 raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order, one item per pixel; each
// item yields exactly one result on the m_ channel: the moved flag, the
// (optionally mirrored) coordinate, the running motion count of the frame
// and an end-of-frame mark. Both channels are valid/ready.
// Each pixel reads its old value from the frame store and writes the new
// one in the same cycle, so one item is taken per clock while s_ready is
// high; the store's single read-write port sets that rate. A result passes
// the store read at the accepting edge, then the squares, compare and
// output registers, and a stall can hold it in any of them.
// When the receiver stalls, items keep entering until the four pipeline
// registers are full, then s_ready drops; nothing is lost.
// After reset the frame store is zeroed one entry per cycle over all
// MAX_WIDTH * MAX_HEIGHT entries, and s_ready stays low until it is done.
// Register writes on the cfg port are taken at any time and must be made
// while the block is idle. The first frame is compared against black.
// ----------------------------------------------------------------------------
module frame_difference_motion_detect (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [fdmd_pkg::IDX_W-1:0] cfg_index,
    input  logic [fdmd_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fdmd_pkg::CHAN_W-1:0] s_pixel_red,
    input  logic [fdmd_pkg::CHAN_W-1:0] s_pixel_green,
    input  logic [fdmd_pkg::CHAN_W-1:0] s_pixel_blue,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_moved,
    output logic [fdmd_pkg::COL_W-1:0] m_coord_x,
    output logic [fdmd_pkg::ROW_W-1:0] m_coord_y,
    output logic [fdmd_pkg::CNT_W-1:0] m_motion_count,
    output logic                       m_frame_last
);
    import fdmd_pkg::*;

    // configuration
    logic [THR_W-1:0]    threshold_reg;
    logic [COL_W-1:0]    width_reg;
    logic [ROW_W-1:0]    height_reg;
    logic                mirror_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            mirror_reg    <= MIRROR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg <= cfg_wr_data[THR_W-1:0];
                REG_WIDTH:     width_reg     <= cfg_wr_data[COL_W-1:0];
                REG_HEIGHT:    height_reg    <= cfg_wr_data[ROW_W-1:0];
                REG_MIRROR:    mirror_reg    <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        thr_sq_reg <= THR_SQ_W'(threshold_reg) * THR_SQ_W'(threshold_reg);
    end

    // pipeline flow control: a stage loads when it is empty or drains
    logic   v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic   take1, take2, take3, take_out;
    logic   accept, clear_busy;
    pos_t   pos;
    tag_t   tag1_reg, tag2_reg, tag3_reg;
    pixel_t cur_reg, old_pix, in_pix;
    logic   moved;

    assign take_out = !out_valid_reg || m_ready;
    assign take3    = !v3_reg || take_out;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;
    assign s_ready  = take1 && !clear_busy;
    assign accept   = s_valid && s_ready;
    assign in_pix   = {s_pixel_red, s_pixel_green, s_pixel_blue};

    fdmd_raster u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (accept),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_mirror (mirror_reg),
        .pos        (pos)
    );

    fdmd_frame_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .access     (accept),
        .addr       (pos.addr),
        .wr_data    (in_pix),
        .rd_data    (old_pix),
        .clear_busy (clear_busy)
    );

    fdmd_diff u_diff (
        .aclk    (aclk),
        .en_sq   (take2),
        .en_cmp  (take3),
        .cur_pix (cur_reg),
        .old_pix (old_pix),
        .thr_sq  (thr_sq_reg),
        .moved   (moved)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take1) v1_reg <= accept;
            if (take2) v2_reg <= v1_reg;
            if (take3) v3_reg <= v2_reg;
            if (take_out) out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag1_reg <= pos.tag;
            cur_reg  <= in_pix;
        end
        if (take2) tag2_reg <= tag1_reg;
        if (take3) tag3_reg <= tag2_reg;
    end

    // per-frame motion count, saturating, restarted after the last pixel
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] out_count_reg;
    tag_t             out_tag_reg;
    logic             out_moved_reg;

    assign cnt_next = (moved && cnt_reg != COUNT_TOP) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take_out && v3_reg) begin
            cnt_reg <= tag3_reg.last ? '0 : cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_out && v3_reg) begin
            out_count_reg <= cnt_next;
            out_tag_reg   <= tag3_reg;
            out_moved_reg <= moved;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_moved        = out_moved_reg;
    assign m_coord_x      = out_tag_reg.x;
    assign m_coord_y      = out_tag_reg.y;
    assign m_motion_count = out_count_reg;
    assign m_frame_last   = out_tag_reg.last;

endmodule

@@ sv/fdmd_raster.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_raster
// Column and row counters: clamps the frame size, gives the store address,
// the reported coordinate and the end-of-frame mark of the next item.
// ----------------------------------------------------------------------------
module fdmd_raster (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [fdmd_pkg::COL_W-1:0] cfg_width,
    input  logic [fdmd_pkg::ROW_W-1:0] cfg_height,
    input  logic                      cfg_mirror,
    output fdmd_pkg::pos_t            pos
);
    import fdmd_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] w_last, col;
    logic [ROW_W-1:0] h_last, row;
    logic             line_end, frame_end;

    always_comb begin
        if (cfg_width == '0) begin
            w_last = '0;
        end else if (cfg_width > COL_W'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = cfg_width - COL_W'(1);
        end
        if (cfg_height == '0) begin
            h_last = '0;
        end else if (cfg_height > ROW_W'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = cfg_height - ROW_W'(1);
        end
    end

    // a counter past a shrunk size ends the line or frame here
    assign col       = (col_reg > w_last) ? w_last : col_reg;
    assign row       = (row_reg > h_last) ? h_last : row_reg;
    assign line_end  = (col == w_last);
    assign frame_end = line_end && (row == h_last);

    assign pos.addr     = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    assign pos.tag.x    = cfg_mirror ? (w_last - col) : col;
    assign pos.tag.y    = row;
    assign pos.tag.last = frame_end;

    always_comb begin
        col_next = col + COL_W'(1);
        row_next = row;
        if (line_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (step) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ sv/fdmd_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_frame_store
// Previous-frame pixel memory: read-before-write at one address per item,
// registered read data, and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module fdmd_frame_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       access,
    input  logic [fdmd_pkg::ADDR_W-1:0] addr,
    input  fdmd_pkg::pixel_t           wr_data,
    output fdmd_pkg::pixel_t           rd_data,
    output logic                       clear_busy
);
    import fdmd_pkg::*;

    pixel_t            mem [FRAME_DEPTH];
    pixel_t            rd_data_reg;
    logic              clear_reg, clear_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              we;
    logic [ADDR_W-1:0] wa;
    pixel_t            wd;

    always_comb begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(FRAME_DEPTH - 1)) begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign we = clear_reg || access;
    assign wa = clear_reg ? clr_addr_reg : addr;
    assign wd = clear_reg ? '0 : wr_data;

    // old contents come out while the new pixel goes in; an item at the same
    // address in the next cycle sees this write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (access) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_reg;

endmodule

@@ sv/fdmd_diff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_diff
// Squared RGB distance between new and stored pixel and the compare
// against the squared threshold, two register stages.
// ----------------------------------------------------------------------------
module fdmd_diff (
    input  logic                         aclk,
    input  logic                         en_sq,
    input  logic                         en_cmp,
    input  fdmd_pkg::pixel_t             cur_pix,
    input  fdmd_pkg::pixel_t             old_pix,
    input  logic [fdmd_pkg::THR_SQ_W-1:0] thr_sq,
    output logic                         moved
);
    import fdmd_pkg::*;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    logic [SQ_W-1:0]  sq_r_reg, sq_g_reg, sq_b_reg;
    logic [SUM_W-1:0] dist_sum;
    logic             moved_reg;

    always_ff @(posedge aclk) begin
        if (en_sq) begin
            sq_r_reg <= sq_diff(cur_pix[3*CHAN_W-1:2*CHAN_W], old_pix[3*CHAN_W-1:2*CHAN_W]);
            sq_g_reg <= sq_diff(cur_pix[2*CHAN_W-1:CHAN_W], old_pix[2*CHAN_W-1:CHAN_W]);
            sq_b_reg <= sq_diff(cur_pix[CHAN_W-1:0], old_pix[CHAN_W-1:0]);
        end
    end

    assign dist_sum = SUM_W'(sq_r_reg) + SUM_W'(sq_g_reg) + SUM_W'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (en_cmp) begin
            moved_reg <= (dist_sum > SUM_W'(thr_sq));
        end
    end

    assign moved = moved_reg;

endmodule

@@ sv/fdmd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmd_checker
// Port-level checks of the motion detector, bound to the top level.
// ----------------------------------------------------------------------------
module fdmd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_moved,
    input logic [fdmd_pkg::COL_W-1:0] m_coord_x,
    input logic [fdmd_pkg::ROW_W-1:0] m_coord_y,
    input logic [fdmd_pkg::CNT_W-1:0] m_motion_count,
    input logic                       m_frame_last
);
    import fdmd_pkg::*;

    // last delivered result, to check how the count steps
    logic             prev_last_reg;
    logic [CNT_W-1:0] prev_count_reg;
    logic [CNT_W-1:0] exp_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_last_reg  <= 1'b1;
            prev_count_reg <= '0;
        end else if (m_valid && m_ready) begin
            prev_last_reg  <= m_frame_last;
            prev_count_reg <= m_motion_count;
        end
    end

    always_comb begin
        if (prev_last_reg) begin
            exp_count = CNT_W'(m_moved);
        end else if (prev_count_reg == COUNT_TOP) begin
            exp_count = COUNT_TOP;
        end else begin
            exp_count = prev_count_reg + CNT_W'(m_moved);
        end
    end

    // store clearing holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coord_x) && $stable(m_coord_y)
            && $stable(m_motion_count) && $stable(m_moved) && $stable(m_frame_last))
        else $error("stalled result changed");

    a_moved_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_moved |-> m_motion_count != '0)
        else $error("moved pixel with zero count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> m_motion_count == exp_count)
        else $error("motion count stepped wrongly");

endmodule

bind frame_difference_motion_detect fdmd_checker u_fdmd_checker (.*);

@@ sim/tb_frame_difference_motion_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_difference_motion_detect
// Self-checking testbench of the frame difference motion detector.
// ----------------------------------------------------------------------------
// Pixels are queued by the main sequence and handed to the block by a clocked
// driver. A copy of the frame store, the raster counters and the motion count
// is kept here. Every accepted pixel is judged against that copy. The
// monitor compares each result, field by field, with the oldest judgment
// still due. A directed part covers channel extremes, the threshold edge,
// clamped and shrunk frame sizes, mirroring and the threshold extremes. Random
// scenes on mostly small frames follow. Registers change only once the block
// has drained, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb_frame_difference_motion_detect;
    import fdmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned ITEM_TARGET = 2000;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             moved;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic [CNT_W-1:0] count;
        logic             last;
    } motion_result_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]   cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [CHAN_W-1:0]  s_pixel_red   = '0;
    logic [CHAN_W-1:0]  s_pixel_green = '0;
    logic [CHAN_W-1:0]  s_pixel_blue  = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_moved;
    logic [COL_W-1:0]   m_coord_x;
    logic [ROW_W-1:0]   m_coord_y;
    logic [CNT_W-1:0]   m_motion_count;
    logic               m_frame_last;

    frame_difference_motion_detect dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_red    (s_pixel_red),
        .s_pixel_green  (s_pixel_green),
        .s_pixel_blue   (s_pixel_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_moved        (m_moved),
        .m_coord_x      (m_coord_x),
        .m_coord_y      (m_coord_y),
        .m_motion_count (m_motion_count),
        .m_frame_last   (m_frame_last)
    );

    // copy of the block's state
    logic [PIX_W-1:0] last_frame [FRAME_DEPTH];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      moved_so_far;
    int unsigned      thr_reg;
    int unsigned      width_reg;
    int unsigned      height_reg;
    bit               mirror_reg;

    rgb_t           pixels_to_send [$];
    motion_result_t detections_due [$];
    int unsigned    pixels_queued;
    int unsigned    mismatches;
    int unsigned    cycles;
    int unsigned    send_gap;
    int unsigned    recv_gap;
    bit             sender_calm;
    bit             receiver_calm;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // frame difference decision for one pixel, advancing the raster state
    task automatic judge_pixel(input logic [CHAN_W-1:0] r, g, b);
        int unsigned    w, h, col, row, addr, dist_sq, x;
        int             dr, dg, db;
        logic [PIX_W-1:0] old;
        motion_result_t res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;
        addr = row * MAX_WIDTH + col;
        old = last_frame[addr];
        last_frame[addr] = {r, g, b};
        dr = int'(r) - int'(old[23:16]);
        dg = int'(g) - int'(old[15:8]);
        db = int'(b) - int'(old[7:0]);
        dist_sq = dr * dr + dg * dg + db * db;
        res.moved = dist_sq > thr_reg * thr_reg;
        if (res.moved && moved_so_far < COUNT_TOP) moved_so_far++;
        x = mirror_reg ? (w - 1 - col) : col;
        res.x = COL_W'(x);
        res.y = ROW_W'(row);
        res.count = CNT_W'(moved_so_far);
        res.last = (col == w - 1) && (row == h - 1);
        detections_due.insert(detections_due.size(), res);
        if (col == w - 1) begin
            col_pos = 0;
            if (res.last) begin
                row_pos = 0;
                moved_so_far = 0;
            end else begin
                row_pos = row + 1;
            end
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        rgb_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) judge_pixel(s_pixel_red, s_pixel_green, s_pixel_blue);
            if (s_valid && !s_ready) begin
                // hold the item until taken
            end else if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pixels_to_send.size() != 0) begin
                nxt = pixels_to_send.pop_front();
                s_valid <= 1'b1;
                s_pixel_red <= nxt.red;
                s_pixel_green <= nxt.green;
                s_pixel_blue <= nxt.blue;
                send_gap <= pick_gap(sender_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        motion_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (detections_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result at (%0d,%0d)",
                                              m_coord_x, m_coord_y));
                end else begin
                    want = detections_due.pop_front();
                    if (m_moved !== want.moved)
                        report_mismatch($sformatf("moved %b, want %b at (%0d,%0d)",
                                                  m_moved, want.moved, want.x, want.y));
                    if (m_coord_x !== want.x)
                        report_mismatch($sformatf("coord_x %0d, want %0d", m_coord_x, want.x));
                    if (m_coord_y !== want.y)
                        report_mismatch($sformatf("coord_y %0d, want %0d", m_coord_y, want.y));
                    if (m_motion_count !== want.count)
                        report_mismatch($sformatf("motion_count %0d, want %0d at (%0d,%0d)",
                                                  m_motion_count, want.count, want.x, want.y));
                    if (m_frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %b, want %b at (%0d,%0d)",
                                                  m_frame_last, want.last, want.x, want.y));
                end
            end
            if (recv_gap != 0) begin
                m_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) recv_gap <= pick_gap(receiver_calm);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, detections_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_pixel(input logic [CHAN_W-1:0] r, g, b);
        rgb_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        pixels_to_send.insert(pixels_to_send.size(), p);
        pixels_queued++;
    endtask

    function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] base,
                                                  input int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return CHAN_W'(v);
    endfunction

    // a steady scene with sensor noise and the odd unrelated pixel
    task automatic queue_scene(input int unsigned n);
        rgb_t        base, p;
        int          spread;
        int unsigned noise_pct;
        base = rgb_t'(PIX_W'($urandom));
        case ($urandom_range(0, 2))
            0: spread = 4;
            1: spread = 30;
            default: spread = 80;
        endcase
        noise_pct = $urandom_range(0, 15);
        repeat (n) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                p = rgb_t'(PIX_W'($urandom));
                push_pixel(p.red, p.green, p.blue);
            end else begin
                push_pixel(jitter(base.red, spread), jitter(base.green, spread),
                           jitter(base.blue, spread));
            end
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= CFG_W'(val);
        case (idx)
            REG_THRESHOLD: thr_reg = val & 'h1FF;
            REG_WIDTH:     width_reg = val & 'h3FF;
            REG_HEIGHT:    height_reg = val & 'h1FF;
            REG_MIRROR:    mirror_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixels_to_send.size() != 0 || s_valid || detections_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic random_settings();
        int unsigned r;
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 99);
            write_reg(REG_THRESHOLD, (r < 10) ? 0 : (r < 15) ? 511 :
                      (r < 25) ? $urandom_range(0, 511) : $urandom_range(15, 100));
        end
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 99);
            write_reg(REG_WIDTH, (r < 10) ? 0 : (r < 18) ? 1023 : (r < 25) ? 640 :
                      $urandom_range(1, 12));
        end
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 99);
            write_reg(REG_HEIGHT, (r < 10) ? 0 : (r < 15) ? 511 : $urandom_range(1, 8));
        end
        if ($urandom_range(0, 9) < 5) write_reg(REG_MIRROR, $urandom_range(0, 1));
        end_writes();
    endtask

    initial begin
        int unsigned scene_no;
        for (int i = 0; i < FRAME_DEPTH; i++) last_frame[i] = '0;
        col_pos = 0;
        row_pos = 0;
        moved_so_far = 0;
        thr_reg = THRESHOLD_RST;
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        mirror_reg = MIRROR_RST;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // first frame against black: channel extremes and the threshold edge
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hFF, 8'h00, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'h00, 8'hFF);
        push_pixel(8'd90, 8'h00, 8'h00);
        push_pixel(8'd91, 8'h00, 8'h00);
        push_pixel(8'h55, 8'hAA, 8'h55);
        wait_drained();

        // line shrinks under the column counter, so this line ends at once
        write_reg(REG_WIDTH, 3);
        end_writes();
        push_pixel(8'hAA, 8'h55, 8'hAA);
        push_pixel(8'h12, 8'h34, 8'h56);
        push_pixel(8'hED, 8'hCB, 8'hA9);
        push_pixel(8'h80, 8'h01, 8'hFE);
        wait_drained();

        // frame shrinks under the row counter; zero threshold, no mirror
        write_reg(REG_HEIGHT, 2);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_MIRROR, 0);
        end_writes();
        push_pixel(8'h12, 8'h34, 8'h56);
        push_pixel(8'hED, 8'hCB, 8'hA9);
        push_pixel(8'h80, 8'h01, 8'hFF);
        wait_drained();

        // zero sizes clamp to one pixel per frame; near-top threshold
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_THRESHOLD, 441);
        end_writes();
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        wait_drained();
        write_reg(REG_THRESHOLD, 511);
        end_writes();
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // oversized registers clamp to the full frame
        write_reg(REG_WIDTH, 1023);
        write_reg(REG_HEIGHT, 511);
        write_reg(REG_THRESHOLD, 90);
        write_reg(REG_MIRROR, 1);
        end_writes();
        push_pixel(8'd91, 8'h00, 8'h00);
        push_pixel(8'h00, 8'h00, 8'h00);
        wait_drained();

        scene_no = 0;
        while (pixels_queued < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            if (scene_no == 3) begin
                // one column, full height: runs through the bottom row
                write_reg(REG_WIDTH, 1);
                write_reg(REG_HEIGHT, 480);
                end_writes();
                queue_scene(480);
            end else begin
                random_settings();
                queue_scene($urandom_range(20, 150));
            end
            // several scenes per setting, so frames repeat over the same content
            repeat ($urandom_range(1, 4)) begin
                while (pixels_to_send.size() != 0) @(posedge aclk);
                queue_scene($urandom_range(10, 60));
            end
            wait_drained();
            scene_no++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/fdmd_pkg.sv
sv/fdmd_raster.sv
sv/fdmd_frame_store.sv
sv/fdmd_diff.sv
sv/frame_difference_motion_detect.sv
sv/fdmd_checker.sv
sim/tb_frame_difference_motion_detect.sv
